[rtl/maze_backtracker_generator_defines.svh]
// Assertion macros for the maze backtracker generator checker.
// Used by the checker file; depends on nothing.
`ifndef MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH
`define MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH
// implication checked on every clock unless reset is low
`define MBG_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define MBG_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/mbg_pkg.sv]
// Shared types and constants for the maze backtracker generator.
// No dependencies.
package mbg_pkg;
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;
  localparam logic [3:0] ALL_WALLS = 4'd15;

  localparam logic [1:0] REQ_STEP  = 2'd0;
  localparam logic [1:0] REQ_PATH  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_OPEN  = 2'd3;

  localparam logic [1:0] ACT_CARVE = 2'd0;
  localparam logic [1:0] ACT_EXTRA = 2'd1;
  localparam logic [1:0] ACT_NONE  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_SX     = 3'd2;
  localparam logic [2:0] CFG_SY     = 3'd3;
  localparam logic [2:0] CFG_EXTRA  = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] pick;
    logic [4:0] ax;
    logic [4:0] ay;
    logic [4:0] bx;
    logic [4:0] by;
    logic [1:0] side;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] out_x;
    logic [4:0] out_y;
    logic [1:0] out_dir;
    logic       answer;
  } out_item_t;
endpackage

[rtl/maze_backtracker_generator.sv]
// Maze backtracker generator: carving, extra openings and wall queries. Depends on mbg_pkg.
// A step reads the stack top, probes its four neighbours and carves one passage, backtracking
// past dead-end cells first; with the stack empty it makes an extra opening or reports nothing left.
// A path test walks cell by cell, or fails with no shared row or column. One item at a time,
// sequenced through the single wall RAM port; the next item can be taken in the strobe cycle.
// Reset (rst_n low, synchronous) holds busy high, then clears the wall RAM one cell a cycle.
module maze_backtracker_generator #(
  parameter int MAX_WIDTH  = mbg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mbg_pkg::MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mbg_pkg::in_item_t    in_item,
  output logic                 out_valid,
  output mbg_pkg::out_item_t   out_item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [9:0]           cfg_data
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  // RAM depth covers every {y, x} address, also for sizes that are not powers of two
  localparam int DEPTH = 1 << AW;
  localparam int CW = $clog2(CELLS + 1);
  // coordinates carried two bits wider, signed, so a step off the edge shows up
  localparam int PW = (XW > YW ? XW : YW) + 2;
  localparam int XMAX = (MAX_WIDTH  < 32) ? MAX_WIDTH  : 32;
  localparam int YMAX = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TOP, S_NB_RD, S_NB_CHK, S_DECIDE, S_CARVE_A, S_CARVE_B,
    S_CARVE_C, S_CARVE_D, S_EXTRA, S_RD, S_RD_CHK, S_PATH, S_PATH_CHK,
    S_OPEN_RD, S_OPEN_WA, S_OPEN_RB, S_OPEN_WB, S_STACK_RD, S_DONE
  } state_t;

  state_t state_r;
  mbg_pkg::in_item_t req_r;
  mbg_pkg::out_item_t res_r;
  logic out_valid_r;

  logic [5:0] gw_r, gh_r;
  logic [4:0] sx_r, sy_r;
  logic [9:0] open_left_r;
  logic [CW-1:0] sp_r;
  logic [AW-1:0] clr_r;
  logic reseed_r;                       // rewrite stack entry 0 after a geometry write

  // wall RAM and stack RAM
  logic [3:0] wall_mem [DEPTH];
  logic [AW-1:0] stk_mem [DEPTH];
  logic [3:0] wall_q;
  logic [AW-1:0] stk_q;

  // cursor into the wall RAM: current cell and helper registers
  logic signed [PW-1:0] cx_r, cy_r;     // top / base cell
  logic signed [PW-1:0] nx_r, ny_r;     // cell being probed
  logic [1:0] k_r, dir_r, od_r;
  logic [3:0] cand_r;                   // candidate per direction
  logic [2:0] ncnt_r;
  logic [PW-1:0] i_r, hi_r;
  logic ans_r;

  // used dimensions
  logic [8:0] uw, uh;
  always_comb begin
    uw = (gw_r < 6'd3) ? 9'd3 : ((32'(gw_r) > XMAX) ? 9'(XMAX) : 9'(gw_r));
    uh = (gh_r < 6'd3) ? 9'd3 : ((32'(gh_r) > YMAX) ? 9'(YMAX) : 9'(gh_r));
  end

  function automatic logic signed [PW-1:0] dx(input logic [1:0] d);
    return (d == mbg_pkg::DIR_E) ? PW'(1) : ((d == mbg_pkg::DIR_W) ? -PW'(1) : '0);
  endfunction
  function automatic logic signed [PW-1:0] dy(input logic [1:0] d);
    return (d == mbg_pkg::DIR_S) ? PW'(1) : ((d == mbg_pkg::DIR_N) ? -PW'(1) : '0);
  endfunction
  // search order W, E, N, S
  function automatic logic [1:0] sdir(input logic [1:0] k);
    case (k)
      2'd0: return mbg_pkg::DIR_W;
      2'd1: return mbg_pkg::DIR_E;
      2'd2: return mbg_pkg::DIR_N;
      default: return mbg_pkg::DIR_S;
    endcase
  endfunction

  function automatic logic in_grid(input logic signed [PW-1:0] x, input logic signed [PW-1:0] y,
                                   input logic [8:0] w, input logic [8:0] h);
    return (x >= 0) && (y >= 0) && (32'(x) < 32'(w)) && (32'(y) < 32'(h));
  endfunction

  function automatic logic [AW-1:0] addr(input logic signed [PW-1:0] x,
                                         input logic signed [PW-1:0] y);
    return {y[YW-1:0], x[XW-1:0]};
  endfunction

  // single shared RAM port: one address, optional write
  logic [AW-1:0] ram_a;
  logic ram_we;
  logic [3:0] ram_wd;
  logic nb_in, cur_in;
  assign nb_in  = in_grid(nx_r, ny_r, uw, uh);
  assign cur_in = in_grid(cx_r, cy_r, uw, uh);

  always_comb begin
    ram_a = addr(nx_r, ny_r);
    ram_we = 1'b0;
    ram_wd = wall_q;
    case (state_r)
      S_CLEAR: begin
        ram_a = clr_r; ram_we = 1'b1; ram_wd = mbg_pkg::ALL_WALLS;
      end
      S_CARVE_B, S_OPEN_WA: begin
        ram_a = addr(cx_r, cy_r); ram_we = cur_in;
        ram_wd = wall_q & ~(4'd1 << od_r);
      end
      S_CARVE_D, S_OPEN_WB: begin
        ram_a = addr(nx_r, ny_r); ram_we = nb_in;
        ram_wd = wall_q & ~(4'd1 << (od_r + 2'd2));
      end
      S_CARVE_A, S_OPEN_RD: ram_a = addr(cx_r, cy_r);
      default: ram_a = addr(nx_r, ny_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) wall_mem[ram_a] <= ram_wd;
    wall_q <= wall_mem[ram_a];
  end

  logic stk_we;
  logic [AW-1:0] stk_wa, stk_wd;
  logic [CW-1:0] stk_ra;
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra[AW-1:0]];
  end

  logic [XW:0] csx;
  logic [YW:0] csy;
  always_comb begin
    csx = (9'(sx_r) > uw - 9'd1) ? (XW+1)'(uw - 9'd1) : (XW+1)'(sx_r);
    csy = (9'(sy_r) > uh - 9'd1) ? (YW+1)'(uh - 9'd1) : (YW+1)'(sy_r);
  end

  // pick mod n for n = 1..4 and selected candidate
  logic [1:0] sel_idx;
  logic [1:0] sel_dir;
  always_comb begin
    case (ncnt_r)
      3'd1: sel_idx = 2'd0;
      3'd2: sel_idx = {1'b0, req_r.pick[0]};
      3'd3: sel_idx = (req_r.pick == 2'd3) ? 2'd0 : req_r.pick;
      default: sel_idx = req_r.pick;
    endcase
    sel_dir = mbg_pkg::DIR_W;
    begin : find
      logic [1:0] seen;
      logic hit;
      seen = 2'd0; hit = 1'b0;
      for (int k = 0; k < 4; k++) begin
        if (cand_r[sdir(2'(k))] && !hit) begin
          if (seen == sel_idx) begin
            sel_dir = sdir(2'(k)); hit = 1'b1;
          end
          seen = seen + 2'd1;
        end
      end
    end
  end

  logic [PW-1:0] ex, ey;
  always_comb begin
    ex = PW'(req_r.ax);
    ey = PW'(req_r.ay);
    if (ex < PW'(1)) ex = PW'(1);
    if (32'(ex) > 32'(uw) - 2) ex = PW'(uw - 9'd2);
    if (ey < PW'(1)) ey = PW'(1);
    if (32'(ey) > 32'(uh) - 2) ey = PW'(uh - 9'd2);
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wa = addr(nx_r, ny_r);
    stk_wd = addr(nx_r, ny_r);
    stk_ra = sp_r - CW'(1);
    if (state_r == S_CARVE_D && 32'(sp_r) < CELLS) begin
      stk_we = 1'b1; stk_wa = sp_r[AW-1:0];
    end
    // start cell from the registers as they stand after the write
    if (reseed_r || state_r == S_CLEAR) begin
      stk_we = 1'b1; stk_wa = '0; stk_wd = {csy[YW-1:0], csx[XW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      reseed_r <= 1'b0;
      gw_r <= 6'd32; gh_r <= 6'd32; sx_r <= '0; sy_r <= '0;
      open_left_r <= 10'd204;
      sp_r <= CW'(1);
    end else begin
      out_valid_r <= 1'b0;
      reseed_r <= cfg_we && (cfg_index <= mbg_pkg::CFG_SY);
      if (cfg_we) begin
        case (cfg_index)
          mbg_pkg::CFG_WIDTH:  begin gw_r <= cfg_data[5:0]; sp_r <= CW'(1); end
          mbg_pkg::CFG_HEIGHT: begin gh_r <= cfg_data[5:0]; sp_r <= CW'(1); end
          mbg_pkg::CFG_SX:     begin sx_r <= cfg_data[4:0]; sp_r <= CW'(1); end
          mbg_pkg::CFG_SY:     begin sy_r <= cfg_data[4:0]; sp_r <= CW'(1); end
          mbg_pkg::CFG_EXTRA:  open_left_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == DEPTH - 1) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          req_r <= in_item;
          res_r <= '0;
          cx_r <= PW'(in_item.ax); cy_r <= PW'(in_item.ay);
          nx_r <= PW'(in_item.ax); ny_r <= PW'(in_item.ay);
          case (in_item.req_type)
            mbg_pkg::REQ_STEP: state_r <= S_STACK_RD;
            mbg_pkg::REQ_READ: state_r <= S_RD;
            mbg_pkg::REQ_PATH: begin
              ans_r <= 1'b1;
              if (in_item.ax == in_item.bx) begin
                nx_r <= PW'(in_item.ax);
                ny_r <= PW'((in_item.ay < in_item.by) ? in_item.ay : in_item.by);
                hi_r <= PW'((in_item.ay < in_item.by) ? in_item.by : in_item.ay);
                i_r  <= PW'((in_item.ay < in_item.by) ? in_item.ay : in_item.by);
                dir_r <= mbg_pkg::DIR_S;
                state_r <= S_PATH;
              end else if (in_item.ay == in_item.by) begin
                ny_r <= PW'(in_item.ay);
                nx_r <= PW'((in_item.ax < in_item.bx) ? in_item.ax : in_item.bx);
                hi_r <= PW'((in_item.ax < in_item.bx) ? in_item.bx : in_item.ax);
                i_r  <= PW'((in_item.ax < in_item.bx) ? in_item.ax : in_item.bx);
                dir_r <= mbg_pkg::DIR_E;
                state_r <= S_PATH;
              end else begin
                ans_r <= 1'b0;
                res_r.action <= mbg_pkg::ACT_QUERY;
                state_r <= S_DONE;
              end
            end
            default: begin
              cx_r <= PW'(uw >> 1); cy_r <= PW'(uh >> 1);
              od_r <= mbg_pkg::DIR_N;
              state_r <= S_OPEN_RD;
            end
          endcase
        end
        S_STACK_RD: begin
          if (sp_r == '0) begin
            if (open_left_r != '0) begin
              cx_r <= ex; cy_r <= ey; od_r <= req_r.side;
              nx_r <= ex + dx(req_r.side); ny_r <= ey + dy(req_r.side);
              open_left_r <= open_left_r - 10'd1;
              res_r.action <= mbg_pkg::ACT_EXTRA;
              res_r.out_x <= 5'(ex); res_r.out_y <= 5'(ey);
              res_r.out_dir <= req_r.side;
              state_r <= S_EXTRA;
            end else begin
              res_r <= '0; res_r.action <= mbg_pkg::ACT_NONE;
              state_r <= S_DONE;
            end
          end else state_r <= S_TOP;
        end
        S_TOP: begin
          cx_r <= PW'(stk_q[XW-1:0]); cy_r <= PW'(stk_q[AW-1:XW]);
          nx_r <= PW'(stk_q[XW-1:0]) + dx(sdir(2'd0));
          ny_r <= PW'(stk_q[AW-1:XW]) + dy(sdir(2'd0));
          k_r <= 2'd0; cand_r <= '0; ncnt_r <= '0;
          state_r <= S_NB_RD;
        end
        S_NB_RD: state_r <= S_NB_CHK;
        S_NB_CHK: begin
          if (nb_in && wall_q == mbg_pkg::ALL_WALLS) begin
            cand_r[sdir(k_r)] <= 1'b1; ncnt_r <= ncnt_r + 3'd1;
          end
          if (k_r == 2'd3) state_r <= S_DECIDE;
          else begin
            k_r <= k_r + 2'd1;
            nx_r <= cx_r + dx(sdir(k_r + 2'd1));
            ny_r <= cy_r + dy(sdir(k_r + 2'd1));
            state_r <= S_NB_RD;
          end
        end
        S_DECIDE: begin
          if (ncnt_r < 3'd2) sp_r <= sp_r - CW'(1);
          if (ncnt_r == '0) state_r <= S_STACK_RD;
          else begin
            od_r <= sel_dir;
            nx_r <= cx_r + dx(sel_dir); ny_r <= cy_r + dy(sel_dir);
            res_r.action <= mbg_pkg::ACT_CARVE;
            res_r.out_x <= 5'(cx_r); res_r.out_y <= 5'(cy_r);
            res_r.out_dir <= sel_dir;
            state_r <= S_CARVE_A;
          end
        end
        S_EXTRA: state_r <= S_CARVE_A;
        S_CARVE_A: state_r <= S_CARVE_B;
        S_CARVE_B: state_r <= S_CARVE_C;
        S_CARVE_C: state_r <= S_CARVE_D;
        S_CARVE_D: begin
          if (res_r.action == mbg_pkg::ACT_CARVE && 32'(sp_r) < CELLS) sp_r <= sp_r + CW'(1);
          state_r <= S_DONE;
        end
        S_RD: state_r <= S_RD_CHK;
        S_RD_CHK: begin
          res_r.action <= mbg_pkg::ACT_QUERY;
          res_r.answer <= nb_in ? wall_q[req_r.side] : 1'b1;
          state_r <= S_DONE;
        end
        S_PATH: begin
          if (i_r == hi_r) begin
            res_r.action <= mbg_pkg::ACT_QUERY; res_r.answer <= ans_r;
            state_r <= S_DONE;
          end else state_r <= S_PATH_CHK;
        end
        S_PATH_CHK: begin
          if (!nb_in || wall_q[dir_r]) begin
            res_r.action <= mbg_pkg::ACT_QUERY; res_r.answer <= 1'b0;
            state_r <= S_DONE;
          end else begin
            i_r <= i_r + PW'(1);
            nx_r <= nx_r + dx(dir_r); ny_r <= ny_r + dy(dir_r);
            state_r <= S_PATH;
          end
        end
        S_OPEN_RD: begin
          nx_r <= cx_r + dx(od_r); ny_r <= cy_r + dy(od_r);
          state_r <= S_OPEN_WA;
        end
        S_OPEN_WA: state_r <= S_OPEN_RB;
        S_OPEN_RB: state_r <= S_OPEN_WB;
        S_OPEN_WB: begin
          if (od_r == mbg_pkg::DIR_W) begin
            res_r.action <= mbg_pkg::ACT_QUERY;
            res_r.out_x <= 5'(cx_r); res_r.out_y <= 5'(cy_r);
            state_r <= S_DONE;
          end else begin
            od_r <= od_r + 2'd1;
            state_r <= S_OPEN_RD;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // busy also covers reset so no item is taken then
  assign busy = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = res_r;
endmodule

[rtl/mbg_checker.sv]
// Port-level checker for the maze backtracker generator, with its bind.
// Depends on mbg_pkg and maze_backtracker_generator_defines.svh.
`include "maze_backtracker_generator_defines.svh"
module mbg_props (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input mbg_pkg::out_item_t out_item
);
  // an accepted item makes the block busy next cycle
  `MBG_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // a result strobe lasts one cycle
  `MBG_ASSERT_NXT(a_strobe_pulse, clk, rst_n, out_valid, !out_valid)
  // result strobe comes when the block has gone idle
  `MBG_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy && $past(busy))
  // nothing-left results carry zero fields
  `MBG_ASSERT_IMP(a_none_zero, clk, rst_n,
    out_valid && out_item.action == mbg_pkg::ACT_NONE,
    out_item.out_x == 5'd0 && out_item.out_y == 5'd0 && out_item.answer == 1'b0)
endmodule

bind maze_backtracker_generator mbg_props u_mbg_props (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

[sim/mbg_checker.sv]
// Checker for the maze backtracker generator: watches the item, result and
// register ports, predicts every result and compares it. Depends on mbg_pkg.
module mbg_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  mbg_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  mbg_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 carves,
  output int                 extras
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbg_pkg::*;

  localparam int CELLS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  logic [3:0] walls [0:CELLS-1];
  int         stk_x [0:CELLS-1];
  int         stk_y [0:CELLS-1];
  int         depth, openings;
  int         cw, ch, csx, csy, cextra;
  out_item_t  expected_q[$];
  int         mism;

  function automatic int used_w();
    return (cw < 3) ? 3 : (cw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cw;
  endfunction

  function automatic int used_h();
    return (ch < 3) ? 3 : (ch > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : ch;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < used_w() && y < used_h();
  endfunction

  function automatic logic [3:0] cell_at(int x, int y);
    if (!on_grid(x, y)) return 4'd0;
    return walls[y * MAX_WIDTH_DEF + x];
  endfunction

  function automatic logic wall_at(int x, int y, logic [1:0] d);
    if (!on_grid(x, y)) return 1'b1;
    return walls[y * MAX_WIDTH_DEF + x][d];
  endfunction

  function automatic int dx_of(logic [1:0] d);
    return (d == DIR_E) ? 1 : (d == DIR_W) ? -1 : 0;
  endfunction

  function automatic int dy_of(logic [1:0] d);
    return (d == DIR_S) ? 1 : (d == DIR_N) ? -1 : 0;
  endfunction

  // clears the wall on both sides; cells off the grid are left alone
  function automatic void knock_down(int x, int y, logic [1:0] d);
    int nx, ny;
    nx = x + dx_of(d);
    ny = y + dy_of(d);
    if (on_grid(x, y)) walls[y * MAX_WIDTH_DEF + x][d] = 1'b0;
    if (on_grid(nx, ny)) walls[ny * MAX_WIDTH_DEF + nx][d + 2'd2] = 1'b0;
  endfunction

  function automatic void reseed_stack();
    stk_x[0] = (csx > used_w() - 1) ? used_w() - 1 : csx;
    stk_y[0] = (csy > used_h() - 1) ? used_h() - 1 : csy;
    depth = 1;
  endfunction

  function automatic logic run_clear(int ax, int ay, int bx, int by);
    int i, lo, hi;
    if (ax == bx) begin
      lo = (ay < by) ? ay : by;
      hi = (ay < by) ? by : ay;
      for (i = lo; i < hi; i++)
        if (wall_at(ax, i, DIR_S)) return 1'b0;
      return 1'b1;
    end
    if (ay == by) begin
      lo = (ax < bx) ? ax : bx;
      hi = (ax < bx) ? bx : ax;
      for (i = lo; i < hi; i++)
        if (wall_at(i, ay, DIR_E)) return 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t carve_or_answer(in_item_t it);
    out_item_t  r;
    logic [1:0] order [4];
    logic [1:0] cand [4];
    logic [1:0] d;
    int         n, k, tx, ty, x, y;
    bit         done;
    r = '0;
    r.action = ACT_NONE;
    order = '{DIR_W, DIR_E, DIR_N, DIR_S};
    done = 0;
    case (it.req_type)
      REQ_STEP: begin
        // backtrack through dead ends until one passage gets carved
        while (depth > 0 && !done) begin
          tx = stk_x[depth-1];
          ty = stk_y[depth-1];
          n = 0;
          for (k = 0; k < 4; k++)
            if (cell_at(tx + dx_of(order[k]), ty + dy_of(order[k])) == ALL_WALLS) begin
              cand[n] = order[k];
              n++;
            end
          if (n < 2) depth--;
          if (n > 0) begin
            d = cand[int'(it.pick) % n];
            knock_down(tx, ty, d);
            if (depth < CELLS) begin
              stk_x[depth] = tx + dx_of(d);
              stk_y[depth] = ty + dy_of(d);
              depth++;
            end
            r.action = ACT_CARVE;
            r.out_x = 5'(tx);
            r.out_y = 5'(ty);
            r.out_dir = d;
            done = 1;
          end
        end
        if (!done && openings > 0) begin
          // extra opening, position pulled into the interior
          x = int'(it.ax);
          y = int'(it.ay);
          if (x < 1) x = 1;
          if (x > used_w() - 2) x = used_w() - 2;
          if (y < 1) y = 1;
          if (y > used_h() - 2) y = used_h() - 2;
          knock_down(x, y, it.side);
          openings--;
          r.action = ACT_EXTRA;
          r.out_x = 5'(x);
          r.out_y = 5'(y);
          r.out_dir = it.side;
        end
      end
      REQ_PATH: begin
        r.action = ACT_QUERY;
        r.answer = run_clear(int'(it.ax), int'(it.ay), int'(it.bx), int'(it.by));
      end
      REQ_READ: begin
        r.action = ACT_QUERY;
        r.answer = wall_at(int'(it.ax), int'(it.ay), it.side);
      end
      default: begin
        x = used_w() / 2;
        y = used_h() / 2;
        for (k = 0; k < 4; k++) knock_down(x, y, k[1:0]);
        r.action = ACT_QUERY;
        r.out_x = 5'(x);
        r.out_y = 5'(y);
      end
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    carves = 0;
    extras = 0;
    mism = 0;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) walls[i] = ALL_WALLS;
      cw = MAX_WIDTH_DEF;
      ch = MAX_HEIGHT_DEF;
      csx = 0;
      csy = 0;
      cextra = 204;
      openings = cextra;
      reseed_stack();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  begin cw = int'(cfg_data[5:0]); reseed_stack(); end
          CFG_HEIGHT: begin ch = int'(cfg_data[5:0]); reseed_stack(); end
          CFG_SX:     begin csx = int'(cfg_data[4:0]); reseed_stack(); end
          CFG_SY:     begin csy = int'(cfg_data[4:0]); reseed_stack(); end
          CFG_EXTRA:  begin cextra = int'(cfg_data); openings = cextra; end
          default: ;
        endcase
      end
      if (start && !busy) expected_q = {expected_q, carve_or_answer(in_item)};
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (mism < 10) $display("unexpected result %p", out_item);
          mism++;
        end else begin
          e = expected_q.pop_front();
          if (e.action == ACT_CARVE) carves++;
          if (e.action == ACT_EXTRA) extras++;
          if (out_item.action !== e.action || out_item.out_x !== e.out_x ||
              out_item.out_y !== e.out_y || out_item.out_dir !== e.out_dir ||
              out_item.answer !== e.answer) begin
            errors++;
            if (mism < 10) $display("result mismatch: expected %p got %p", e, out_item);
            mism++;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

[sim/tb_maze_backtracker_generator.sv]
// Top of the maze backtracker generator testbench: clock, reset, requests and
// register writes, and the verdict. Depends on mbg_pkg, mbg_checker and the block.
module tb_maze_backtracker_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import mbg_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;
  int        errors, pending, carves, extras;
  int        sent;
  int        gw, gh;   // grid size in use, for aiming the random coordinates

  always #4 clk = ~clk;

  maze_backtracker_generator DUT (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  mbg_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .carves, .extras
  );

  // Present one item and hold it until the block takes it. start stays high
  // afterwards; the next call either replaces the item or drops start for a gap.
  task automatic issue(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
          ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Lower start and let every outstanding result drain before touching registers.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic program_regs(int w, int h, int sx, int sy, int extra);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_WIDTH;  cfg_data <= 10'(w);
    @(negedge clk);
    cfg_index <= CFG_HEIGHT; cfg_data <= 10'(h);
    @(negedge clk);
    cfg_index <= CFG_SX;     cfg_data <= 10'(sx);
    @(negedge clk);
    cfg_index <= CFG_SY;     cfg_data <= 10'(sy);
    @(negedge clk);
    cfg_index <= CFG_EXTRA;  cfg_data <= 10'(extra);
    @(negedge clk);
    cfg_we <= 1'b0;
    gw = (w < 3) ? 3 : (w > 32) ? 32 : w;
    gh = (h < 3) ? 3 : (h > 32) ? 32 : h;
  endtask

  function automatic in_item_t mk(logic [1:0] rq, int p, int ax, int ay,
                                  int bx, int by, int sd);
    in_item_t it;
    it.req_type = rq; it.pick = 2'(p); it.ax = 5'(ax); it.ay = 5'(ay);
    it.bx = 5'(bx); it.by = 5'(by); it.side = 2'(sd);
    return it;
  endfunction

  // Mostly steps so the carve runs deep; queries aimed at the grid in use,
  // with the odd coordinate anywhere in the full 5-bit range.
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    it.pick = 2'($urandom_range(0, 3));
    it.side = 2'($urandom_range(0, 3));
    it.ax = 5'($urandom_range(0, 31));
    it.ay = 5'($urandom_range(0, 31));
    it.bx = 5'($urandom_range(0, 31));
    it.by = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    it.req_type = (r < 72) ? REQ_STEP : (r < 84) ? REQ_PATH : (r < 96) ? REQ_READ : REQ_OPEN;
    if ($urandom_range(0, 5) != 0) begin
      it.ax = 5'($urandom_range(0, gw - 1));
      it.ay = 5'($urandom_range(0, gh - 1));
      it.bx = 5'($urandom_range(0, gw - 1));
      it.by = 5'($urandom_range(0, gh - 1));
    end
    // straight runs need a shared row or column
    r = $urandom_range(0, 4);
    if (r < 2) it.bx = it.ax;
    else if (r < 4) it.by = it.ay;
    return it;
  endfunction

  task automatic random_phase(int w, int h, int sx, int sy, int extra, int n);
    settle();
    program_regs(w, h, sx, sy, extra);
    repeat (n) issue(random_item());
  endtask

  initial begin
    sent = 0;
    gw = 32;
    gh = 32;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reads at the corners, every side, path corner cases, centre, steps
    issue(mk(REQ_READ, 0, 0, 0, 0, 0, DIR_N));
    issue(mk(REQ_READ, 0, 31, 31, 0, 0, DIR_E));
    issue(mk(REQ_READ, 0, 31, 0, 0, 0, DIR_S));
    issue(mk(REQ_READ, 0, 0, 31, 0, 0, DIR_W));
    issue(mk(REQ_PATH, 0, 7, 9, 7, 9, 0));      // same cell twice
    issue(mk(REQ_PATH, 0, 1, 2, 3, 4, 0));      // no shared row or column
    issue(mk(REQ_PATH, 0, 0, 5, 31, 5, 0));     // walled row
    issue(mk(REQ_OPEN, 0, 0, 0, 0, 0, 0));
    issue(mk(REQ_PATH, 0, 16, 17, 16, 15, 0));  // through the opened centre
    issue(mk(REQ_PATH, 0, 17, 16, 15, 16, 0));
    issue(mk(REQ_READ, 0, 16, 16, 0, 0, DIR_W));
    for (int p = 0; p < 4; p++) issue(mk(REQ_STEP, p, 0, 0, 0, 0, 0));
    issue(mk(REQ_STEP, 3, 31, 31, 31, 31, 3));
    issue(mk(REQ_READ, 0, 0, 0, 0, 0, DIR_E));

    // register settings from the clamped minimum to beyond the maximum
    random_phase(0, 0, 31, 31, 3, 50);
    random_phase(5, 4, 1, 2, 0, 70);
    random_phase(63, 63, 0, 31, 1023, 480);
    random_phase(10, 32, 5, 5, 5, 150);
    random_phase(32, 3, 31, 0, 20, 150);
    random_phase(17, 9, 8, 4, 1, 120);
    settle();

    $display("%0d requests sent: %0d passages carved, %0d extra walls removed,",
             sent, carves, extras);
    $display("six register settings from a clamped 3x3 grid to the full 32x32 grid");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
